@@ rtl/core/tshc_pkg.sv @@
// package with types and constants of the track size and hover classifier
`default_nettype none

package tshc_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SIDE_W  = 16;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CNT_W   = 2;

    localparam logic [STAMP_W-1:0] DEFAULT_HOVER_MS = 32'd1000;
    localparam logic [CNT_W-1:0]   COUNT_LIMIT      = 2'd2;

    localparam logic [IDX_W-1:0] REG_SIZE_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOVER_SPAN = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOVER_TIME = 3'd5;

    typedef enum logic [1:0] {
        CLASS_SMALL  = 2'd0,
        CLASS_LARGE  = 2'd1,
        CLASS_OTHER  = 2'd2,
        CLASS_TARGET = 2'd3
    } size_class_t;

    typedef enum logic [1:0] {
        CONF_LOW    = 2'd0,
        CONF_MEDIUM = 2'd1,
        CONF_HIGH   = 2'd2
    } conf_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  size_min;
        logic [SIDE_W-1:0]  size_max;
        logic [SIDE_W-1:0]  target_min;
        logic [SIDE_W-1:0]  target_max;
        logic [COORD_W-1:0] hover_span;
        logic [STAMP_W-1:0] hover_time;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] lowest_x;
        logic [COORD_W-1:0] highest_x;
        logic [COORD_W-1:0] lowest_y;
        logic [COORD_W-1:0] highest_y;
        logic [STAMP_W-1:0] oldest_stamp;
        logic [STAMP_W-1:0] newest_stamp;
        logic [CNT_W-1:0]   position_count;
    } acc_t;

endpackage

`default_nettype wire

@@ rtl/core/tshc_if.sv @@
// channel interfaces for positions in and classification results out
`default_nettype none

interface tshc_in_if;
    import tshc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [STAMP_W-1:0] stamp;
    logic               first_of_track;
    logic               last_of_track;
    logic [SIDE_W-1:0]  box_width;
    logic [SIDE_W-1:0]  box_height;

    modport source (
        output valid, pos_x, pos_y, stamp, first_of_track, last_of_track,
               box_width, box_height,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, stamp, first_of_track, last_of_track,
               box_width, box_height,
        output ready
    );
endinterface

interface tshc_out_if;
    import tshc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         size_class;
    logic               hovering;
    logic [STAMP_W-1:0] track_age;
    logic [STAMP_W-1:0] hover_duration;
    logic [1:0]         confidence;

    modport source (
        output valid, size_class, hovering, track_age, hover_duration, confidence,
        input  ready
    );

    modport sink (
        input  valid, size_class, hovering, track_age, hover_duration, confidence,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/tshc_cfg_regs.sv @@
// configuration register file with reset defaults
`default_nettype none

module tshc_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tshc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tshc_pkg::CFG_W-1:0] cfg_data,
    output tshc_pkg::cfg_t                 cfg
);
    import tshc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE_MIN:   cfg_next.size_min   = cfg_data[SIDE_W-1:0];
                REG_SIZE_MAX:   cfg_next.size_max   = cfg_data[SIDE_W-1:0];
                REG_TARGET_MIN: cfg_next.target_min = cfg_data[SIDE_W-1:0];
                REG_TARGET_MAX: cfg_next.target_max = cfg_data[SIDE_W-1:0];
                REG_HOVER_SPAN: cfg_next.hover_span = cfg_data[COORD_W-1:0];
                REG_HOVER_TIME: cfg_next.hover_time = cfg_data[STAMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_min   <= 16'd18;
            cfg_reg.size_max   <= 16'd100;
            cfg_reg.target_min <= 16'd18;
            cfg_reg.target_max <= 16'd50;
            cfg_reg.hover_span <= 16'd50;
            cfg_reg.hover_time <= 32'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/tshc_track_acc.sv @@
// running bounds, timestamps and position count of the current track
`default_nettype none

module tshc_track_acc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [tshc_pkg::COORD_W-1:0] pos_x,
    input  wire logic [tshc_pkg::COORD_W-1:0] pos_y,
    input  wire logic [tshc_pkg::STAMP_W-1:0] stamp,
    input  wire logic                        first_of_track,
    input  wire logic                        last_of_track,
    output tshc_pkg::acc_t                   acc_upd
);
    import tshc_pkg::*;

    acc_t acc_reg;
    acc_t acc_next;
    logic restart;

    assign restart = first_of_track || (acc_reg.position_count == '0);

    // state including the current position
    always_comb
    begin
        if (restart)
        begin
            acc_upd.lowest_x       = pos_x;
            acc_upd.highest_x      = pos_x;
            acc_upd.lowest_y       = pos_y;
            acc_upd.highest_y      = pos_y;
            acc_upd.oldest_stamp   = stamp;
            acc_upd.newest_stamp   = stamp;
            acc_upd.position_count = CNT_W'(1);
        end
        else
        begin
            acc_upd.lowest_x     = (pos_x < acc_reg.lowest_x)   ? pos_x : acc_reg.lowest_x;
            acc_upd.highest_x    = (pos_x > acc_reg.highest_x)  ? pos_x : acc_reg.highest_x;
            acc_upd.lowest_y     = (pos_y < acc_reg.lowest_y)   ? pos_y : acc_reg.lowest_y;
            acc_upd.highest_y    = (pos_y > acc_reg.highest_y)  ? pos_y : acc_reg.highest_y;
            acc_upd.oldest_stamp = acc_reg.oldest_stamp;
            acc_upd.newest_stamp = stamp;
            acc_upd.position_count = (acc_reg.position_count < COUNT_LIMIT)
                                   ? acc_reg.position_count + CNT_W'(1)
                                   : acc_reg.position_count;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (advance)
        begin
            acc_next = acc_upd;
            if (last_of_track)
            begin
                acc_next.position_count = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tshc_result.sv @@
// size class, age, hover decision, hover duration and confidence, held in the result register
`default_nettype none

module tshc_result (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire tshc_pkg::acc_t             acc_upd,
    input  wire logic [tshc_pkg::SIDE_W-1:0] box_width,
    input  wire logic [tshc_pkg::SIDE_W-1:0] box_height,
    input  wire tshc_pkg::cfg_t             cfg,
    output logic                            busy,
    tshc_out_if.source                      result
);
    import tshc_pkg::*;

    logic               valid_reg, valid_next;
    size_class_t        class_reg, class_next;
    logic               hover_reg, hover_next;
    logic [STAMP_W-1:0] age_reg, age_next;
    logic [STAMP_W-1:0] dur_reg, dur_next;
    conf_t              conf_reg, conf_next;

    logic [SIDE_W-1:0]  side;
    logic [SIDE_W-1:0]  lo, hi, tlo, thi;
    logic [COORD_W-1:0] range_x, range_y, range_max;
    logic [STAMP_W-1:0] limit;
    logic               two_or_more;

    always_comb
    begin
        side = (box_width > box_height) ? box_width : box_height;
        lo   = (cfg.size_min < cfg.size_max) ? cfg.size_min : cfg.size_max;
        hi   = (cfg.size_min > cfg.size_max) ? cfg.size_min : cfg.size_max;
        tlo  = (cfg.target_min < cfg.target_max) ? cfg.target_min : cfg.target_max;
        thi  = (cfg.target_min > cfg.target_max) ? cfg.target_min : cfg.target_max;

        priority if (side < lo)
            class_next = CLASS_SMALL;
        else if (side > hi)
            class_next = CLASS_LARGE;
        else if (side >= tlo && side <= thi)
            class_next = CLASS_TARGET;
        else
            class_next = CLASS_OTHER;

        two_or_more = (acc_upd.position_count >= COUNT_LIMIT);
        age_next    = two_or_more ? acc_upd.newest_stamp - acc_upd.oldest_stamp : '0;
        limit       = (cfg.hover_time == '0) ? DEFAULT_HOVER_MS : cfg.hover_time;
        range_x     = acc_upd.highest_x - acc_upd.lowest_x;
        range_y     = acc_upd.highest_y - acc_upd.lowest_y;
        range_max   = (range_x > range_y) ? range_x : range_y;

        hover_next = (class_next == CLASS_TARGET) && two_or_more &&
                     (range_max <= cfg.hover_span) && (age_next >= limit);
        dur_next   = hover_next ? age_next : '0;

        if (class_next != CLASS_TARGET)
            conf_next = CONF_LOW;
        else if (hover_next)
            conf_next = CONF_HIGH;
        else
            conf_next = CONF_MEDIUM;
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= class_next;
            hover_reg <= hover_next;
            age_reg   <= age_next;
            dur_reg   <= dur_next;
            conf_reg  <= conf_next;
        end
    end

    // result register full and not drained this cycle
    assign busy = valid_reg && !result.ready;

    assign result.valid          = valid_reg;
    assign result.size_class     = class_reg;
    assign result.hovering       = hover_reg;
    assign result.track_age      = age_reg;
    assign result.hover_duration = dur_reg;
    assign result.confidence     = conf_reg;

endmodule

`default_nettype wire

@@ rtl/core/track_size_hover_classifier_top.sv @@
// track size and hover classifier top level
// an accepted position goes to the input register, and a last position then to the result register
// throughput: one position per cycle while no last position waits in the input register stage
// a last position waits in the input register while an earlier result is not taken
// reset clears the pipeline valids and position count and loads register defaults
`default_nettype none

module track_size_hover_classifier_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [tshc_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [tshc_pkg::CFG_W-1:0]  cfg_data,
    tshc_in_if.sink                          track,
    tshc_out_if.source                       result
);
    import tshc_pkg::*;

    cfg_t cfg;
    acc_t acc_upd;

    logic               in_valid_reg, in_valid_next;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               first_reg, last_reg;
    logic [SIDE_W-1:0]  width_reg, height_reg;

    logic busy;
    logic advance;
    logic take;

    assign advance     = in_valid_reg && !(last_reg && busy);
    assign track.ready = !in_valid_reg || advance;
    assign take        = track.valid && track.ready;

    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg      <= track.pos_x;
            y_reg      <= track.pos_y;
            stamp_reg  <= track.stamp;
            first_reg  <= track.first_of_track;
            last_reg   <= track.last_of_track;
            width_reg  <= track.box_width;
            height_reg <= track.box_height;
        end
    end

    tshc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tshc_track_acc u_acc (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .pos_x          (x_reg),
        .pos_y          (y_reg),
        .stamp          (stamp_reg),
        .first_of_track (first_reg),
        .last_of_track  (last_reg),
        .acc_upd        (acc_upd)
    );

    tshc_result u_res (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && last_reg),
        .acc_upd    (acc_upd),
        .box_width  (width_reg),
        .box_height (height_reg),
        .cfg        (cfg),
        .busy       (busy),
        .result     (result)
    );

endmodule

`default_nettype wire
